FILE: sv/rms_pkg.sv
//------------------------------------------------------------------------------
// rms_pkg: shared types, sizes and helpers for the block RMS engine.
// Holds the sample and result beat types, the accumulator status struct,
// the sequencer states and the sample magnitude helper.
//------------------------------------------------------------------------------
package rms_pkg;

    // Block limits.
    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 16;

    // Fixed field widths of the two channels.
    localparam int SAMPLE_W   = 16;
    localparam int RMS_W      = 16;
    localparam int CNT_OUT_W  = 13;

    // Derived internal widths.
    localparam int COUNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W      = 2 * SAMPLE_BITS - 1 + $clog2(MAX_SAMPLES);
    localparam int ROOT_W     = (SUM_W + 1) / 2;
    localparam int EXT_W      = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
    localparam int SQ_TOP     = 2 * ((SUM_W - 1) / 2);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } smp_beat_t;

    typedef struct packed {
        logic [RMS_W-1:0]     rms;
        logic [CNT_OUT_W-1:0] sample_count;
        logic                 overflow;
    } res_beat_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               overflowed;
    } acc_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_ROOT,
        S_PUT
    } state_t;

    // Magnitude of the low SAMPLE_BITS bits of a sample, read as two's complement.
    function automatic logic [SAMPLE_BITS-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] s);
        logic [EXT_W-1:0]       ext;
        logic [SAMPLE_BITS-1:0] raw;
        ext = EXT_W'($unsigned(s));
        raw = ext[SAMPLE_BITS-1:0];
        return raw[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - raw) : raw;
    endfunction

endpackage

FILE: sv/rms_sqacc.sv
//------------------------------------------------------------------------------
// rms_sqacc: bit-serial square and accumulate.
// Squares one sample magnitude by shift and add, one multiplier bit per
// cycle, straight into the running sum; also keeps the count and drop flag.
//------------------------------------------------------------------------------
module rms_sqacc
    import rms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SAMPLE_BITS-1:0] mag,
    input  logic                   clear,
    output logic                   done,
    output acc_state_t             acc
);

    logic                     busy_reg, busy_next;
    logic [SAMPLE_BITS-1:0]   mplier_reg, mplier_next;
    logic [2*SAMPLE_BITS-1:0] mcand_reg, mcand_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic                     full;

    assign full = (count_reg >= COUNT_W'(MAX_SAMPLES));
    assign done = busy_reg && (mplier_reg == '0);
    assign acc  = '{sum: sum_reg, count: count_reg, overflowed: ovf_reg};

    always_comb
    begin
        busy_next   = busy_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            mcand_next = (2*SAMPLE_BITS)'(mag);
            if (full)
            begin
                // The block is already full: the sample is dropped.
                ovf_next    = 1'b1;
                mplier_next = '0;
            end
            else
            begin
                mplier_next = mag;
                count_next  = count_reg + 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    sum_next = sum_reg + SUM_W'(mcand_reg);
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
        end
        if (clear)
        begin
            sum_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
    end

`ifndef NO_ASSERTIONS
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_SAMPLES))
        else $error("sample count went past the block limit");
`endif

endmodule

FILE: sv/rms_div.sv
//------------------------------------------------------------------------------
// rms_div: restoring divider, one quotient bit per cycle.
// Divides the sum of squares by the sample count to give the floor of the mean.
//------------------------------------------------------------------------------
module rms_div
    import rms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [SUM_W-1:0]   quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]   dvs_reg, dvs_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [COUNT_W:0]     trial;
    logic [COUNT_W:0]     diff;
    logic                 ge;

    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign diff     = trial - {1'b0, dvs_reg};
    assign done     = busy_reg && (step_reg == '0);
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_CNT_W'(SUM_W);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], ge};
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (dvs_reg != '0)) |-> (rem_reg < dvs_reg))
        else $error("divider finished with a remainder not below the divisor");
`endif

endmodule

FILE: sv/rms_isqrt.sv
//------------------------------------------------------------------------------
// rms_isqrt: digit-by-digit integer square root.
// Settles one root bit per cycle, working on two bits of the radicand at a time.
//------------------------------------------------------------------------------
module rms_isqrt
    import rms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic             busy_reg, busy_next;
    logic [SUM_W-1:0] v_reg, v_next;
    logic [SUM_W:0]   r_reg, r_next;
    logic [SUM_W-1:0] bit_reg, bit_next;
    logic [SUM_W:0]   rb;
    logic [SUM_W:0]   vd;
    logic             ge;

    assign rb   = r_reg + (SUM_W+1)'(bit_reg);
    assign ge   = ((SUM_W+1)'(v_reg) >= rb);
    assign vd   = (SUM_W+1)'(v_reg) - rb;
    assign done = busy_reg && (bit_reg == '0);
    assign root = r_reg[ROOT_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            v_next    = value;
            r_next    = '0;
            bit_next  = SUM_W'(1) << SQ_TOP;
        end
        else if (busy_reg)
        begin
            if (bit_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (ge)
                begin
                    v_next = vd[SUM_W-1:0];
                    r_next = (r_reg >> 1) + (SUM_W+1)'(bit_reg);
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
    end

`ifndef NO_ASSERTIONS
    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (r_reg[SUM_W:ROOT_W] == '0))
        else $error("square root result is wider than the root width");
`endif

endmodule

FILE: sv/rms_of_sample_block.sv
//------------------------------------------------------------------------------
// rms_of_sample_block: RMS of a block of signed samples.
// Squares and sums each sample bit-serially, then on the marked last sample
// divides by the count and takes the integer square root, one bit per cycle.
//
//   channel   direction   handshake              beat payload
//   smp       in          smp_valid / smp_stall  sample, last
//   res       out         res_valid / res_stall  rms, sample_count, overflow
//
// A sample beat holds off the next one until the shift-and-add squarer has
// stepped through every bit of its magnitude (at most SAMPLE_BITS bits); a
// dropped sample skips the squaring. After the last beat the engine runs the
// divider, then the square root, and then loads the result register.
// Reset clears the sum, the count, the drop flag and the handshake state.
// The result sits in an output register; a stalled result holds the engine
// only when the next block result is ready to be written over it.
//------------------------------------------------------------------------------
module rms_of_sample_block
    import rms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      smp_valid,
    output logic      smp_stall,
    input  smp_beat_t smp_data,
    output logic      res_valid,
    input  logic      res_stall,
    output res_beat_t res_data
);

    state_t             state_reg, state_next;
    logic               last_reg, last_next;
    logic [COUNT_W-1:0] cnt_res_reg, cnt_res_next;
    logic               ovf_res_reg, ovf_res_next;
    logic               res_valid_reg, res_valid_next;
    res_beat_t          res_reg, res_next;

    logic               smp_take;
    logic               res_free;

    logic               sq_start;
    logic               sq_clear;
    logic               sq_done;
    acc_state_t         acc;

    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   quotient;

    logic               root_start;
    logic [SUM_W-1:0]   root_value;
    logic               root_done;
    logic [ROOT_W-1:0]  root;

    // Samples are taken only while the engine is idle.
    assign smp_stall = (state_reg != S_IDLE);
    assign smp_take  = smp_valid && !smp_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign res_free  = !res_valid_reg || !res_stall;

    // A zero count cannot close a block, but it is kept safe: the mean is zero.
    assign root_value = (cnt_res_reg == '0) ? '0 : quotient;

    rms_sqacc u_sqacc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .mag   (sample_mag(smp_data.sample)),
        .clear (sq_clear),
        .done  (sq_done),
        .acc   (acc)
    );

    rms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc.sum),
        .divisor  (acc.count),
        .done     (div_done),
        .quotient (quotient)
    );

    rms_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (root_value),
        .done  (root_done),
        .root  (root)
    );

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        cnt_res_next   = cnt_res_reg;
        ovf_res_next   = ovf_res_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        sq_start       = 1'b0;
        sq_clear       = 1'b0;
        div_start      = 1'b0;
        root_start     = 1'b0;

        // A result beat leaves when the downstream side takes it.
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (smp_take)
                begin
                    sq_start   = 1'b1;
                    last_next  = smp_data.last;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (sq_done)
                begin
                    if (last_reg)
                    begin
                        // Close the block: hand the sum to the divider, keep the
                        // count and flag for the result, and clear the totals.
                        div_start    = 1'b1;
                        cnt_res_next = acc.count;
                        ovf_res_next = acc.overflowed;
                        sq_clear     = 1'b1;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    root_start = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (res_free)
                begin
                    res_next.rms          = RMS_W'(root);
                    res_next.sample_count = CNT_OUT_W'(cnt_res_reg);
                    res_next.overflow     = ovf_res_reg;
                    res_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        cnt_res_reg <= cnt_res_next;
        ovf_res_reg <= ovf_res_next;
        res_reg     <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_result_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_PUT))
        else $error("result register loaded outside the result hand-off");

    a_take_starts_acc: assert property (@(posedge clk) disable iff (!rst_n)
        smp_take |=> (state_reg == S_ACC))
        else $error("accepted sample did not start the squarer");
`endif

endmodule

FILE: sim/tb_rms_of_sample_block.sv
//------------------------------------------------------------------------------
// tb_rms_of_sample_block: self-checking testbench for the block RMS engine.
// Sample beats are queued up front and handed to a clocked driver. A clocked
// monitor feeds every accepted sample into a local model of the sum of squares
// and the count. It checks each result beat, field by field, against the
// oldest expected one. The run covers short directed blocks and random blocks
// of mixed length under three idling profiles.
//------------------------------------------------------------------------------
module tb_rms_of_sample_block;
    import rms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Idling profiles. Each queued beat carries the profile it belongs to, so
    // the profile changes exactly where the stream crosses from one to the next.
    typedef enum int {
        PH_RECV_SLOW,
        PH_SEND_SLOW,
        PH_FULL_RATE
    } phase_t;

    // One queued sample beat. When hold_for_drain is set, the driver keeps the
    // beat back until every outstanding result has come out of the block.
    typedef struct {
        smp_beat_t beat;
        bit        hold_for_drain;
        phase_t    phase;
    } queued_beat_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      smp_valid = 1'b0;
    logic      smp_stall;
    smp_beat_t smp_data = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_beat_t res_data;

    queued_beat_t pending[$];
    res_beat_t    results_due[$];

    // Local copy of the accumulator state that the block keeps between beats.
    logic [63:0] square_total = '0;
    int          taken = 0;
    bit          dropped = 1'b0;

    // Set at each rising edge when a sample beat went in, so that the driver
    // knows at the following falling edge whether it may move on.
    bit     smp_fire = 1'b0;
    phase_t live_phase = PH_RECV_SLOW;
    int     mismatches = 0;

    rms_of_sample_block dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Percent of cycles in which the sender holds back a beat.
    function automatic int send_gap_pct(phase_t ph);
        case (ph)
            PH_RECV_SLOW: return 6;
            PH_SEND_SLOW: return 72;
            default:      return 0;
        endcase
    endfunction

    // Percent of cycles in which the receiver stalls the result channel.
    function automatic int recv_hold_pct(phase_t ph);
        case (ph)
            PH_RECV_SLOW: return 72;
            PH_SEND_SLOW: return 6;
            default:      return 0;
        endcase
    endfunction

    // Largest r with r * r <= v, found one bit at a time from the top.
    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (32'd1 << i);
            if (64'(t) * 64'(t) <= v)
                r = t;
        end
        return r;
    endfunction

    // Adds one accepted sample to the running sum of squares. A marked sample
    // closes the block: the expected result is queued and the state cleared.
    // Past the sample limit a sample, marked or not, is not added and sets the drop flag.
    function automatic void take_sample(smp_beat_t b);
        longint      v;
        logic [63:0] mean;
        res_beat_t   r;
        v = $signed(b.sample);
        if (v < 0)
            v = -v;
        if (taken < MAX_SAMPLES)
        begin
            square_total += 64'(v * v);
            taken++;
        end
        else
            dropped = 1'b1;
        if (b.last)
        begin
            mean = (taken != 0) ? square_total / 64'(taken) : 64'd0;
            r.rms          = RMS_W'(floor_root(mean));
            r.sample_count = CNT_OUT_W'(taken);
            r.overflow     = dropped;
            results_due.push_back(r);
            square_total = '0;
            taken        = 0;
            dropped      = 1'b0;
        end
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: mismatch: %s", $time, msg);
    endfunction

    function automatic void check_result(res_beat_t got);
        res_beat_t want;
        if (results_due.size() == 0)
        begin
            flag_mismatch($sformatf("result beat with none expected: rms=%0d count=%0d ovf=%0d",
                                    got.rms, got.sample_count, got.overflow));
            return;
        end
        want = results_due.pop_front();
        if (got.rms !== want.rms || got.sample_count !== want.sample_count
            || got.overflow !== want.overflow)
            flag_mismatch($sformatf("expected rms=%0d count=%0d ovf=%0d, got rms=%0d count=%0d ovf=%0d",
                                    want.rms, want.sample_count, want.overflow,
                                    got.rms, got.sample_count, got.overflow));
    endfunction

    // Driver. Inputs change only at the falling edge. A beat stays on the bus
    // until the rising edge that takes it; only then does the next one, or a
    // gap, take its place. The result stall is drawn fresh every cycle.
    always @(negedge clk)
    begin : drive_samples
        queued_beat_t head;
        if (rst_n)
        begin
            if (!smp_valid || smp_fire)
            begin
                if (pending.size() != 0
                    && !(pending[0].hold_for_drain && results_due.size() != 0)
                    && $urandom_range(99) >= send_gap_pct(pending[0].phase))
                begin
                    head = pending.pop_front();
                    live_phase = head.phase;
                    smp_data  <= head.beat;
                    smp_valid <= 1'b1;
                end
                else
                    smp_valid <= 1'b0;
            end
            res_stall <= ($urandom_range(99) < recv_hold_pct(live_phase));
        end
    end

    // Monitor. Both channels are sampled at the rising edge, where the values
    // seen are the ones that were settled before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            smp_fire = smp_valid && !smp_stall;
            if (smp_fire)
                take_sample(smp_data);
            if (res_valid && !res_stall)
                check_result(res_data);
        end
    end

    task automatic add_beat(logic [15:0] s, bit mark, phase_t ph, bit hold);
        queued_beat_t q;
        q.beat.sample     = s;
        q.beat.last       = mark;
        q.hold_for_drain  = hold;
        q.phase           = ph;
        pending.push_back(q);
    endtask

    // Full-scale values, small values around zero, and a wide random mix that
    // toggles every bit of the sample field.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random blocks, mostly short so that results come often, with a few long
    // ones. Now and then a block waits for the engine to drain before it starts.
    task automatic add_random_blocks(phase_t ph, int beats);
        int made;
        int len;
        made = 0;
        while (made < beats)
        begin
            case ($urandom_range(19))
                0:       len = $urandom_range(200, 41);
                1, 2, 3,
                4, 5:    len = $urandom_range(40, 9);
                default: len = $urandom_range(8, 1);
            endcase
            for (int k = 0; k < len; k++)
                add_beat(pick_sample(), k == len - 1, ph, k == 0 && $urandom_range(24) == 0);
            made += len;
        end
    endtask

    initial
    begin
        // Directed blocks: single-sample blocks at zero and at both ends of the
        // range, a mixed-sign block, and alternating bit patterns.
        add_beat(16'h0000, 1'b1, PH_RECV_SLOW, 1'b0);
        add_beat(16'h8000, 1'b1, PH_RECV_SLOW, 1'b0);
        add_beat(16'h7FFF, 1'b1, PH_RECV_SLOW, 1'b0);
        add_beat(16'hFFFF, 1'b1, PH_RECV_SLOW, 1'b0);
        add_beat(16'h0001, 1'b0, PH_RECV_SLOW, 1'b0);
        add_beat(16'hFFFF, 1'b0, PH_RECV_SLOW, 1'b0);
        add_beat(16'h0002, 1'b0, PH_RECV_SLOW, 1'b0);
        add_beat(16'hFFFE, 1'b1, PH_RECV_SLOW, 1'b0);
        add_beat(16'h7FFF, 1'b0, PH_RECV_SLOW, 1'b0);
        add_beat(16'h8000, 1'b0, PH_RECV_SLOW, 1'b0);
        add_beat(16'h0000, 1'b1, PH_RECV_SLOW, 1'b0);
        add_beat(16'h0003, 1'b0, PH_RECV_SLOW, 1'b0);
        add_beat(16'h0004, 1'b1, PH_RECV_SLOW, 1'b0);
        add_beat(16'h5555, 1'b0, PH_RECV_SLOW, 1'b0);
        add_beat(16'hAAAA, 1'b0, PH_RECV_SLOW, 1'b0);
        add_beat(16'h0F0F, 1'b1, PH_RECV_SLOW, 1'b0);
        add_random_blocks(PH_RECV_SLOW, 620);

        // The first block of the second profile always waits for the engine
        // to go quiet, so the sender pauses at least once.
        add_beat(16'h1234, 1'b1, PH_SEND_SLOW, 1'b1);
        add_random_blocks(PH_SEND_SLOW, 630);
        add_random_blocks(PH_FULL_RATE, 640);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the stream to run dry and every result to come back, then
        // give the divider and root time to show any stray result.
        while (pending.size() != 0 || smp_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
